FILE: hdl/ame_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ame_pkg
// Shared types, constants and the quarter-wave sine table of the effect block.
// ----------------------------------------------------------------------------
package ame_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ADDR_W      = 15;
    localparam int SEEN_W      = 16;
    localparam int QUARTER_LEN = 64;
    localparam int QIDX_W      = 7;
    localparam logic [SEEN_W-1:0] SEEN_CAP = 16'd32768;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam logic [2:0] MODE_ECHO   = 3'd0;
    localparam logic [2:0] MODE_REVERB = 3'd1;
    localparam logic [2:0] MODE_DIST   = 3'd2;
    localparam logic [2:0] MODE_CHORUS = 3'd3;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_DELAY  = 3'd1;
    localparam logic [2:0] REG_FB     = 3'd2;
    localparam logic [2:0] REG_DRIVE  = 3'd3;
    localparam logic [2:0] REG_CLIP   = 3'd4;
    localparam logic [2:0] REG_DEPTH  = 3'd5;
    localparam logic [2:0] REG_LFO    = 3'd6;

    typedef struct packed {
        logic [2:0]  effect_mode;
        logic [14:0] delay_length;
        logic [15:0] feedback_gain;
        logic [15:0] drive_gain;
        logic [14:0] clip_level;
        logic [10:0] chorus_depth;
        logic [31:0] lfo_step;
    } ame_cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic [2:0]                 mode;
        logic                       add_tap;
        logic                       zero_dist;
        logic [ADDR_W-1:0]          raddr;
        logic [ADDR_W-1:0]          waddr;
    } ame_item_t;

    typedef logic [14:0] qsine_t [0:QUARTER_LEN];

    // sine by a Taylor series in Q30, scaled to 0..32767 for the table, evaluated at elaboration only
    function automatic qsine_t build_qsine();
        qsine_t tab;
        longint t;
        longint t2;
        longint term;
        longint sum;
        longint v;
        for (int k = 0; k <= QUARTER_LEN; k++)
        begin
            t    = (longint'(k) * HALF_PI_Q30) / QUARTER_LEN;
            t2   = (t * t) >>> 30;
            term = t;
            sum  = t;
            for (int n = 1; n <= 6; n++)
            begin
                term = (term * t2) >>> 30;
                // divide by (2n)(2n+1)
                case (n)
                    1:       term = term / 64'sd6;
                    2:       term = term / 64'sd20;
                    3:       term = term / 64'sd42;
                    4:       term = term / 64'sd72;
                    5:       term = term / 64'sd110;
                    default: term = term / 64'sd156;
                endcase
                if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            if (sum < 0)
                sum = 0;
            v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
            if (v > 32767)
                v = 32767;
            tab[k] = v[14:0];
        end
        return tab;
    endfunction

    localparam qsine_t QSINE = build_qsine();

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767)
            return 16'sh7FFF;
        else if (v < -20'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

endpackage

FILE: hdl/ame_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ame_front
// Accepts samples, tracks buffer position and LFO, works out the tap distance.
// ----------------------------------------------------------------------------
module ame_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ame_pkg::ame_cfg_t     cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [15:0]           in_sample,
    input  logic                  in_start,
    output logic                  item_valid,
    input  logic                  item_ready,
    output ame_pkg::ame_item_t    item
);
    import ame_pkg::*;

    logic [ADDR_W-1:0] wp_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [31:0]       phase_reg;

    logic                       s1_v_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg;
    logic [2:0]                 s1_mode_reg;
    logic [SEEN_W-1:0]          s1_seen_reg;
    logic [ADDR_W-1:0]          s1_wp_reg;
    logic signed [15:0]         s1_sin_reg;

    logic                       s2_v_reg;
    logic signed [SAMPLE_W-1:0] s2_x_reg;
    logic [2:0]                 s2_mode_reg;
    logic [SEEN_W-1:0]          s2_seen_reg;
    logic [ADDR_W-1:0]          s2_wp_reg;
    logic [26:0]                s2_prod_reg;

    logic              accept;
    logic              s1_move;
    logic              s2_take;
    logic [SEEN_W-1:0] seen_eff;
    logic [31:0]       phase_eff;
    logic [7:0]        tidx;
    logic [QIDX_W-1:0] qidx;
    logic [14:0]       mag;
    logic signed [15:0] sin_val;
    logic [16:0]       sin_ofs;
    logic [10:0]       q0;
    logic [16:0]       rem;
    logic [10:0]       chorus_dist;
    logic [ADDR_W-1:0] tap_dist;

    assign s2_take  = s2_v_reg && item_ready;
    assign s1_move  = s1_v_reg && (!s2_v_reg || s2_take);
    assign in_ready = !s1_v_reg || s1_move;
    assign accept   = in_valid && in_ready;

    assign seen_eff  = in_start ? '0 : seen_reg;
    assign phase_eff = in_start ? '0 : phase_reg;
    assign tidx      = phase_eff[31:24];
    assign qidx      = tidx[6] ? (QIDX_W'(QUARTER_LEN) - {1'b0, tidx[5:0]})
                               : {1'b0, tidx[5:0]};
    assign mag       = QSINE[qidx];
    assign sin_val   = tidx[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign sin_ofs   = 17'($signed({s1_sin_reg[15], s1_sin_reg}) + 17'sd32767);

    // depth*(s+32767)/65534: estimate by >>16, one correction step
    assign q0          = s2_prod_reg[26:16];
    assign rem         = {1'b0, s2_prod_reg[15:0]} + {5'b0, q0, 1'b0};
    assign chorus_dist = q0 + {10'b0, (rem >= 17'd65534)};
    assign tap_dist    = (s2_mode_reg == MODE_CHORUS) ? {4'b0, chorus_dist}
                                                      : cfg.delay_length;

    always_comb
    begin
        item.x         = s2_x_reg;
        item.mode      = s2_mode_reg;
        item.zero_dist = (tap_dist == '0);
        item.add_tap   = (s2_seen_reg >= {1'b0, tap_dist}) &&
                         ((s2_mode_reg == MODE_ECHO) || (s2_mode_reg == MODE_REVERB) ||
                          (s2_mode_reg == MODE_CHORUS));
        item.raddr     = s2_wp_reg - tap_dist;
        item.waddr     = s2_wp_reg;
    end
    assign item_valid = s2_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            seen_reg  <= '0;
            phase_reg <= '0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg    <= wp_reg + 1'b1;
                seen_reg  <= (seen_eff < SEEN_CAP) ? seen_eff + 1'b1 : seen_eff;
                phase_reg <= phase_eff + cfg.lfo_step;
            end
            if (accept)
                s1_v_reg <= 1'b1;
            else if (s1_move)
                s1_v_reg <= 1'b0;
            if (s1_move)
                s2_v_reg <= 1'b1;
            else if (s2_take)
                s2_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= $signed(in_sample);
            s1_mode_reg <= cfg.effect_mode;
            s1_seen_reg <= seen_eff;
            s1_wp_reg   <= wp_reg;
            s1_sin_reg  <= sin_val;
        end
        if (s1_move)
        begin
            s2_x_reg    <= s1_x_reg;
            s2_mode_reg <= s1_mode_reg;
            s2_seen_reg <= s1_seen_reg;
            s2_wp_reg   <= s1_wp_reg;
            s2_prod_reg <= 27'(cfg.chorus_depth) * 27'(sin_ofs[15:0]);
        end
    end

endmodule

FILE: hdl/ame_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ame_queue
// Four-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module ame_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  ame_pkg::ame_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output ame_pkg::ame_item_t pop_item
);
    import ame_pkg::*;

    ame_item_t  slot_reg [0:3];
    logic [1:0] wr_reg;
    logic [1:0] rd_reg;
    logic [2:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 3'd4);
    assign pop_valid  = (cnt_reg != 3'd0);
    assign pop_item   = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_item;
    end

endmodule

FILE: hdl/ame_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ame_back
// History memory read, effect mix and write-back; holds the output register.
// ----------------------------------------------------------------------------
module ame_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  ame_pkg::ame_cfg_t  cfg,
    input  logic               item_valid,
    output logic               item_ready,
    input  ame_pkg::ame_item_t item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        out_sample
);
    import ame_pkg::*;

    localparam logic ST_READ = 1'b0;
    localparam logic ST_MIX  = 1'b1;

    logic signed [SAMPLE_W-1:0] hist_mem [0:(1 << ADDR_W) - 1];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    ame_item_t                  ent_reg;
    logic                       state_reg;
    logic                       out_v_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic                       mix_go;
    logic signed [SAMPLE_W-1:0] tap;
    logic signed [32:0]         fb_prod;
    logic signed [33:0]         fb_rnd;
    logic signed [32:0]         dr_prod;
    logic signed [33:0]         dr_rnd;
    logic signed [25:0]         dr_val;
    logic signed [25:0]         clip_pos;
    logic signed [16:0]         half_rnd;
    logic signed [SAMPLE_W-1:0] y;

    assign item_ready = (state_reg == ST_READ);
    assign mix_go     = (state_reg == ST_MIX) && (!out_v_reg || out_ready);
    assign tap        = ent_reg.zero_dist ? ent_reg.x : rd_data_reg;

    assign fb_prod  = tap * $signed({1'b0, cfg.feedback_gain});
    assign fb_rnd   = {fb_prod[32], fb_prod} + 34'sd16384;
    assign dr_prod  = ent_reg.x * $signed({1'b0, cfg.drive_gain});
    assign dr_rnd   = {dr_prod[32], dr_prod} + 34'sd128;
    assign dr_val   = dr_rnd[33:8];
    assign clip_pos = $signed({11'b0, cfg.clip_level});
    assign half_rnd = {tap[15], tap} + 17'sd1;

    always_comb
    begin
        y = ent_reg.x;
        case (ent_reg.mode)
            MODE_ECHO, MODE_REVERB:
            begin
                if (ent_reg.add_tap)
                    y = sat16(20'(ent_reg.x) + 20'($signed(fb_rnd[33:15])));
            end
            MODE_DIST:
            begin
                if (dr_val > clip_pos)
                    y = clip_pos[15:0];
                else if (dr_val < -clip_pos)
                    y = 16'(-clip_pos);
                else
                    y = dr_val[15:0];
            end
            MODE_CHORUS:
            begin
                if (ent_reg.add_tap)
                    y = sat16(20'(ent_reg.x) + 20'($signed(half_rnd[16:1])));
            end
            default:
            begin
                y = ent_reg.x;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_READ;
            out_v_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_READ:
                begin
                    if (item_valid)
                        state_reg <= ST_MIX;
                end
                ST_MIX:
                begin
                    if (mix_go)
                        state_reg <= ST_READ;
                end
                default:
                begin
                    state_reg <= ST_READ;
                end
            endcase
            if (mix_go)
                out_v_reg <= 1'b1;
            else if (out_ready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            ent_reg     <= item;
            rd_data_reg <= hist_mem[item.raddr];
        end
        if (mix_go)
        begin
            // reverb keeps its own output in history
            hist_mem[ent_reg.waddr] <= (ent_reg.mode == MODE_REVERB) ? y : ent_reg.x;
            out_reg                 <= y;
        end
    end

    assign out_valid  = out_v_reg;
    assign out_sample = out_reg;

endmodule

FILE: hdl/audio_multi_effect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_multi_effect
// Echo, comb reverb, distortion and chorus on a Q1.15 sample stream.
// ----------------------------------------------------------------------------
// One sample in gives one sample out. The back end reads the 32768-entry history
// memory, then mixes and writes back once the output is free, and takes no new
// sample until that is done. Each sample passes two front pipeline stages, which
// work out the LFO sine and tap distance, then queue, read and mix. No clearing
// pass is needed after reset: a tap is only used once the buffer has that many
// samples behind it. The user must write registers only while no sample is in
// flight; the block itself does not enforce this.
module audio_multi_effect
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
    input  logic        s_axis_tuser,   // [0] start_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample_out
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data
);
    import ame_pkg::*;

    ame_cfg_t  cfg_reg;
    ame_item_t f_item;
    ame_item_t q_item;
    logic      f_valid;
    logic      f_ready;
    logic      q_valid;
    logic      q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.effect_mode   <= 3'd0;
            cfg_reg.delay_length  <= 15'd24000;
            cfg_reg.feedback_gain <= 16'd16384;
            cfg_reg.drive_gain    <= 16'd1280;
            cfg_reg.clip_level    <= 15'd26214;
            cfg_reg.chorus_depth  <= 11'd960;
            cfg_reg.lfo_step      <= 32'd178957;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MODE:  cfg_reg.effect_mode   <= cfg_data[2:0];
                REG_DELAY: cfg_reg.delay_length  <= cfg_data[14:0];
                REG_FB:    cfg_reg.feedback_gain <= cfg_data[15:0];
                REG_DRIVE: cfg_reg.drive_gain    <= cfg_data[15:0];
                REG_CLIP:  cfg_reg.clip_level    <= cfg_data[14:0];
                REG_DEPTH: cfg_reg.chorus_depth  <= cfg_data[10:0];
                REG_LFO:   cfg_reg.lfo_step      <= cfg_data;
                default:   ;
            endcase
        end
    end

    ame_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (s_axis_tdata),
        .in_start   (s_axis_tuser),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    ame_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    ame_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (m_axis_tdata)
    );

endmodule

FILE: tb/tb_audio_multi_effect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_multi_effect
// Self-checking bench for the multi-effect audio block.
// ----------------------------------------------------------------------------
// A scoreboard class mirrors the effect state: history, write position, sample
// count, LFO phase and the registers. Accepted input samples are run through
// that mirror, and the predicted samples are compared in order with the output
// stream. The run has a directed part over each effect and its corner cases,
// random register settings with random samples, and an echo run at the
// deepest delay. Both stream sides idle and stall at random outside no_idle runs.
module tb_audio_multi_effect;
    import ame_pkg::*;

class effect_scoreboard;
    logic signed [15:0] history [0:32767];
    logic [14:0]        wpos;
    int unsigned        seen;
    logic [31:0]        phase;
    ame_cfg_t           cfg;
    longint             qsin [0:64];
    logic [15:0]        expected_q [$];
    int                 errors;

    function new();
        longint t;
        longint t2;
        longint term;
        longint acc;
        longint v;
        for (int k = 0; k <= 64; k++)
        begin
            t = (longint'(k) * 64'sd1686629713) / 64;
            t2 = (t * t) >>> 30;
            term = t;
            acc = t;
            for (int n = 1; n <= 6; n++)
            begin
                term = ((term * t2) >>> 30) / longint'(2 * n * (2 * n + 1));
                acc = (n % 2 == 1) ? acc - term : acc + term;
            end
            if (acc < 0)
                acc = 0;
            v = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
            qsin[k] = (v > 32767) ? 32767 : v;
        end
        wpos = '0;
        seen = 0;
        phase = '0;
        errors = 0;
        cfg.effect_mode = 3'd0;
        cfg.delay_length = 15'd24000;
        cfg.feedback_gain = 16'd16384;
        cfg.drive_gain = 16'd1280;
        cfg.clip_level = 15'd26214;
        cfg.chorus_depth = 11'd960;
        cfg.lfo_step = 32'd178957;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            REG_MODE:  cfg.effect_mode = v[2:0];
            REG_DELAY: cfg.delay_length = v[14:0];
            REG_FB:    cfg.feedback_gain = v[15:0];
            REG_DRIVE: cfg.drive_gain = v[15:0];
            REG_CLIP:  cfg.clip_level = v[14:0];
            REG_DEPTH: cfg.chorus_depth = v[10:0];
            REG_LFO:   cfg.lfo_step = v;
            default: ;
        endcase
    endfunction

    function longint round_down(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function longint clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function longint tap(int unsigned tap_dist, longint cur);
        logic [14:0] a;
        a = wpos - tap_dist[14:0];
        if (tap_dist == 0)
            return cur;
        return longint'(history[a]);
    endfunction

    function void note_input(logic signed [15:0] x, bit start);
        longint xs;
        longint y;
        longint p;
        longint c;
        longint s;
        longint gain;
        int unsigned tap_dist;
        logic [7:0] idx;
        xs = x;
        y = xs;
        if (start)
        begin
            seen = 0;
            phase = '0;
        end
        case (cfg.effect_mode)
            MODE_ECHO, MODE_REVERB:
            begin
                tap_dist = cfg.delay_length;
                gain = cfg.feedback_gain;
                if (seen >= tap_dist)
                    y = clamp16(xs + round_down(tap(tap_dist, xs) * gain, 15));
            end
            MODE_DIST:
            begin
                gain = cfg.drive_gain;
                c = cfg.clip_level;
                p = round_down(xs * gain, 8);
                y = (p > c) ? c : ((p < -c) ? -c : p);
            end
            MODE_CHORUS:
            begin
                idx = phase[31:24];
                s = idx[6] ? qsin[64 - idx[5:0]] : qsin[idx[5:0]];
                if (idx[7])
                    s = -s;
                gain = cfg.chorus_depth;
                tap_dist = int'((gain * (s + 32767)) / 65534);
                if (seen >= tap_dist)
                    y = clamp16(xs + round_down(tap(tap_dist, xs), 1));
            end
            default: ;
        endcase
        history[wpos] = (cfg.effect_mode == MODE_REVERB) ? y[15:0] : x;
        wpos = wpos + 1'b1;
        if (seen < 32768)
            seen++;
        phase = phase + cfg.lfo_step;
        expected_q.push_back(y[15:0]);
    endfunction

    function void check_result(logic [15:0] got);
        logic [15:0] want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected sample_out, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (got !== want)
        begin
            $display("%0t: sample_out mismatch, expected %h, actual %h", $time, want, got);
            errors++;
        end
    endfunction
endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_data;

    effect_scoreboard sb;
    bit no_idle;

    audio_multi_effect uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls before each request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    task automatic send_sample(logic [15:0] x, bit start);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= x;
        s_axis_tuser <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(x, start);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic apply_cfg(ame_cfg_t c);
        logic [31:0] vals [7];
        vals[REG_MODE] = c.effect_mode;
        vals[REG_DELAY] = c.delay_length;
        vals[REG_FB] = c.feedback_gain;
        vals[REG_DRIVE] = c.drive_gain;
        vals[REG_CLIP] = c.clip_level;
        vals[REG_DEPTH] = c.chorus_depth;
        vals[REG_LFO] = c.lfo_step;
        for (int i = 0; i < 7; i++)
        begin
            cfg_we <= 1'b1;
            cfg_addr <= i[2:0];
            cfg_data <= vals[i];
            @(posedge clk);
            sb.set_reg(i[2:0], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic ame_cfg_t rand_cfg();
        ame_cfg_t c;
        c.effect_mode = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
            0: c.delay_length = 15'd0;
            1: c.delay_length = 15'd1;
            2: c.delay_length = 15'($urandom);
            3, 4: c.delay_length = 15'($urandom_range(1, 120));
            default: c.delay_length = 15'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 4))
            0: c.feedback_gain = 16'd32768;
            1: c.feedback_gain = 16'd0;
            2: c.feedback_gain = 16'hFFFF;
            default: c.feedback_gain = 16'($urandom);
        endcase
        c.drive_gain = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom);
        c.clip_level = ($urandom_range(0, 4) == 0) ? 15'd0 : 15'($urandom);
        case ($urandom_range(0, 4))
            0: c.chorus_depth = 11'd2047;
            1: c.chorus_depth = 11'($urandom);
            default: c.chorus_depth = 11'($urandom_range(0, 40));
        endcase
        case ($urandom_range(0, 4))
            0: c.lfo_step = 32'hFFFF_FFFF;
            1: c.lfo_step = $urandom_range(0, 1 << 26);
            default: c.lfo_step = $urandom;
        endcase
        return c;
    endfunction

    initial
    begin
        ame_cfg_t c;
        int n;
        sb = new();
        no_idle = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each effect at its extremes, with start flags and short history
        c = sb.cfg;
        c.effect_mode = MODE_ECHO;
        c.delay_length = 15'd2;
        c.feedback_gain = 16'd32768;
        apply_cfg(c);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0001, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        drain();
        c.effect_mode = MODE_REVERB;
        c.delay_length = 15'd0;
        apply_cfg(c);
        send_sample(16'h4000, 1'b1);
        send_sample(16'hC000, 1'b0);
        send_sample(16'h0000, 1'b0);
        drain();
        c.effect_mode = MODE_DIST;
        c.drive_gain = 16'hFFFF;
        c.clip_level = 15'h7FFF;
        apply_cfg(c);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        drain();
        c.clip_level = 15'd0;
        c.drive_gain = 16'd0;
        apply_cfg(c);
        send_sample(16'h1234, 1'b0);
        drain();
        c.effect_mode = MODE_CHORUS;
        c.chorus_depth = 11'd0;
        apply_cfg(c);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        drain();
        c.chorus_depth = 11'd2047;
        c.lfo_step = 32'h4000_0000;
        apply_cfg(c);
        for (int i = 0; i < 4; i++)
            send_sample(16'h2000, i == 0);
        drain();
        for (int m = 4; m < 8; m++)
        begin
            c.effect_mode = m[2:0];
            apply_cfg(c);
            send_sample(16'h8000, 1'b0);
            drain();
        end

        // random settings, random samples
        for (int ph = 0; ph < 12; ph++)
        begin
            no_idle = (ph % 5 == 2);
            apply_cfg(rand_cfg());
            n = $urandom_range(100, 200);
            for (int i = 0; i < n; i++)
                send_sample(rand_sample(), ($urandom_range(0, 199) == 0) || (i == 0));
            drain();
        end

        // echo at the deepest delay: the tap stays out of reach
        no_idle = 1'b1;
        c = rand_cfg();
        c.effect_mode = MODE_ECHO;
        c.delay_length = 15'h7FFF;
        apply_cfg(c);
        for (int i = 0; i < 200; i++)
            send_sample(rand_sample(), i == 0);
        drain();

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
hdl/ame_pkg.sv
hdl/ame_front.sv
hdl/ame_queue.sv
hdl/ame_back.sv
hdl/audio_multi_effect.sv
tb/tb_audio_multi_effect.sv
